// ===== rtl/bdq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue unit.
// ---------------------------------------------------------------------------
package bdq_pkg;

   // payload widths
   localparam int DATA_W     = 32;
   localparam int ACTION_W   = 3;
   localparam int CAP_W      = 5;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = 2'd0;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word reported for front and rear when nothing is held
   localparam logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

   // action codes of an input item
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_REPORT     = 3'd4
   } action_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_FETCH = 2'd1,
      ST_LOAD  = 2'd2
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic exec;   // carry out the accepted item's action
      logic load;   // capture the result into the output register
   } cmd_type;

endpackage

// ===== rtl/bdq_req_if.sv =====
// ---------------------------------------------------------------------------
// bdq_req_if
// Input channel: one action item per valid/ready handshake.
// ---------------------------------------------------------------------------
interface bdq_req_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);

endinterface

// ===== rtl/bdq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// bdq_rsp_if
// Result channel: one status item per valid/ready handshake.
// ---------------------------------------------------------------------------
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] rear_value;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, accepted, front_value, rear_value, is_empty, is_full,
                   input ready);
   modport sink   (input valid, accepted, front_value, rear_value, is_empty, is_full,
                   output ready);

endinterface

// ===== rtl/bdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accepts an item, waits for the ring read, then loads the
// output register when it is free.
// ---------------------------------------------------------------------------
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::cmd_type cmd
);
   import bdq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   // output register can take a new item
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.exec  = req_valid;
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            cmd.load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // an accepted item always passes through the fetch state to the load state
   a_exec_to_load: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> ##1 (state_ff == ST_LOAD))
      else $error("accepted item did not reach load state");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.load)
      else $error("result register overwritten while held");

   // a load always presents a result next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff)
      else $error("load did not raise result valid");

endmodule

// ===== rtl/bdq_dpath.sv =====
// ---------------------------------------------------------------------------
// bdq_dpath
// Ring store with head index and entry count, registered front/rear reads
// and the result register.
// ---------------------------------------------------------------------------
module bdq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bdq_pkg::cmd_type                  cmd,
   input  logic [bdq_pkg::CAP_W-1:0]         capacity,
   input  logic [bdq_pkg::ACTION_W-1:0]      action,
   input  logic signed [bdq_pkg::DATA_W-1:0] value,
   output logic                              accepted,
   output logic signed [bdq_pkg::DATA_W-1:0] front_value,
   output logic signed [bdq_pkg::DATA_W-1:0] rear_value,
   output logic                              is_empty,
   output logic                              is_full
);
   import bdq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ring index
   localparam int CW = $clog2(DEPTH + 1);                  // entry count
   localparam int SW = CW + 1;                             // index sums
   localparam int KW = (CW > CAP_W) ? CW : CAP_W;          // capacity compare

   // ring memory, no reset
   logic [DATA_W-1:0] ring_mem [DEPTH];

   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              accepted_ff, accepted_in;
   logic [DATA_W-1:0] rd_front_ff, rd_rear_ff;

   logic [IW-1:0]     head_dec, head_inc, tail_idx, rear_idx;
   logic [SW-1:0]     tail_sum, rear_sum;
   logic [CW-1:0]     rear_off;
   logic [KW-1:0]     cap_raw, cap_eff;
   logic              full, empty;
   logic              wr_en;
   logic [IW-1:0]     wr_idx;

   // effective capacity: zero counts as one, clamped to the ring size
   assign cap_raw = KW'(capacity);
   always_comb begin
      cap_eff = cap_raw;
      if (cap_raw == '0) begin
         cap_eff = KW'(1);
      end else if (cap_raw > KW'(DEPTH)) begin
         cap_eff = KW'(DEPTH);
      end
   end

   assign empty = (count_ff == '0);
   assign full  = (KW'(count_ff) >= cap_eff);

   // ring index arithmetic with wrap at DEPTH
   assign head_dec = (head_ff == '0) ? IW'(DEPTH - 1) : IW'(head_ff - 1'b1);
   assign head_inc = (head_ff == IW'(DEPTH - 1)) ? '0 : IW'(head_ff + 1'b1);

   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail_idx = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);

   assign rear_off = empty ? '0 : CW'(count_ff - 1'b1);
   assign rear_sum = SW'(head_ff) + SW'(rear_off);
   assign rear_idx = (rear_sum >= SW'(DEPTH)) ? IW'(rear_sum - SW'(DEPTH)) : IW'(rear_sum);

   // action decode and state update
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      accepted_in = accepted_ff;
      wr_en       = 1'b0;
      wr_idx      = tail_idx;
      if (cmd.exec) begin
         accepted_in = 1'b0;
         unique case (action_type'(action))
            ACT_PUSH_FRONT: begin
               if (!full) begin
                  head_in     = head_dec;
                  wr_en       = 1'b1;
                  wr_idx      = head_dec;
                  count_in    = CW'(count_ff + 1'b1);
                  accepted_in = 1'b1;
               end
            end
            ACT_PUSH_BACK: begin
               if (!full) begin
                  wr_en       = 1'b1;
                  wr_idx      = tail_idx;
                  count_in    = CW'(count_ff + 1'b1);
                  accepted_in = 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (!empty) begin
                  head_in     = head_inc;
                  count_in    = CW'(count_ff - 1'b1);
                  accepted_in = 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (!empty) begin
                  count_in    = CW'(count_ff - 1'b1);
                  accepted_in = 1'b1;
               end
            end
            ACT_REPORT: begin
               accepted_in = 1'b1;
            end
            default: begin
               // undefined codes: refused, nothing changes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
   end

   // ring write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_idx] <= value;
      end
      rd_front_ff <= ring_mem[head_ff];
      rd_rear_ff  <= ring_mem[rear_idx];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         accepted    <= accepted_ff;
         front_value <= empty ? EMPTY_WORD : rd_front_ff;
         rear_value  <= empty ? EMPTY_WORD : rd_rear_ff;
         is_empty    <= empty;
         is_full     <= full;
      end
   end

   // count and head stay within the ring
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)) && (head_ff <= IW'(DEPTH - 1)))
      else $error("head or count out of range");

   // occupancy moves only on an executed item
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> (count_ff == $past(count_ff)) && (head_ff == $past(head_ff)))
      else $error("state changed without an item");

   // a push into a full deque is refused and leaves the count alone
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK))
      |=> (!accepted_ff && (count_ff == $past(count_ff))))
      else $error("push accepted while full");

endmodule

// ===== rtl/bounded_double_ended_queue_unit.sv =====
// ---------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Double-ended queue bounded by a programmable capacity, held in a ring
// memory with a head index and an entry count.
// ---------------------------------------------------------------------------
// Each request item pushes a word at either end, pops from either end or
// only reports; a push when full, a pop when empty or an undefined code is
// refused. Every item yields one result with the accepted flag, the front
// and rear words (all ones when empty) and the empty and full flags after
// the action. An item goes through the idle, fetch and load states: the
// action and ring write happen at acceptance, the registered ring read of
// the front and rear entries happens in fetch, and the result is loaded
// into the output register in load. The result register decouples the two
// sides, so the next item is taken while a result still waits; a stalled
// result channel holds the unit in its load step. Capacity sits at byte
// address 0 (5 bits, reset 16); zero acts as one and values above DEPTH
// act as DEPTH. Write it only while the unit is idle.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   bdq_req_if.sink                           req_chan,
   bdq_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bdq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bdq_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bdq_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import bdq_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             csr_wr;
   cmd_type          cmd;

   // configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_CAPACITY_ADDR);

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr) capacity_in = pwdata[CAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = (paddr == CSR_CAPACITY_ADDR) ? CSR_DATA_W'(capacity_ff) : '0;

   // sequencer
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // ring store and result register
   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .capacity    (capacity_ff),
      .action      (req_chan.action),
      .value       (req_chan.value),
      .accepted    (rsp_chan.accepted),
      .front_value (rsp_chan.front_value),
      .rear_value  (rsp_chan.rear_value),
      .is_empty    (rsp_chan.is_empty),
      .is_full     (rsp_chan.is_full)
   );

endmodule

// ===== tb/bdq_deque_checker.sv =====
// ---------------------------------------------------------------------------
// bdq_deque_checker
// Watches the request, result and register ports of the deque unit, keeps
// its own copy of the ring, head, count and capacity, and compares every
// result item field by field with the status predicted for its request.
// ---------------------------------------------------------------------------
module bdq_deque_checker (
   input  logic                           clock,
   input  logic                           reset,
   bdq_req_if                             req_mon,
   bdq_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bdq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bdq_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatch_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bdq_pkg::*;

   localparam int RING_DEPTH = 16;

   typedef struct packed {
      logic              accepted;
      logic [DATA_W-1:0] front_word;
      logic [DATA_W-1:0] rear_word;
      logic              empty;
      logic              full;
   } deque_status_type;

   // shadow of the deque
   logic [DATA_W-1:0] ring_words [RING_DEPTH];
   int                head_idx;
   int                entry_cnt;
   logic [CAP_W-1:0]  capacity_reg;

   deque_status_type  pending_status [$];

   function automatic int limit_capacity();
      int lim;
      lim = int'(capacity_reg);
      if (lim == 0) lim = 1;
      if (lim > RING_DEPTH) lim = RING_DEPTH;
      return lim;
   endfunction

   // carries out one action on the shadow and returns the status after it
   function automatic deque_status_type apply_deque_action(logic [ACTION_W-1:0] act,
                                                           logic [DATA_W-1:0] word);
      deque_status_type st;
      int               lim;
      logic             was_full;
      logic             was_empty;
      lim       = limit_capacity();
      was_full  = (entry_cnt >= lim);
      was_empty = (entry_cnt == 0);
      st        = '0;
      case (action_type'(act))
         ACT_PUSH_FRONT: begin
            if (!was_full) begin
               head_idx = (head_idx == 0) ? RING_DEPTH - 1 : head_idx - 1;
               ring_words[head_idx] = word;
               entry_cnt++;
               st.accepted = 1'b1;
            end
         end
         ACT_PUSH_BACK: begin
            if (!was_full) begin
               ring_words[(head_idx + entry_cnt) % RING_DEPTH] = word;
               entry_cnt++;
               st.accepted = 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (!was_empty) begin
               head_idx = (head_idx + 1) % RING_DEPTH;
               entry_cnt--;
               st.accepted = 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (!was_empty) begin
               entry_cnt--;
               st.accepted = 1'b1;
            end
         end
         ACT_REPORT: begin
            st.accepted = 1'b1;
         end
         default: begin
            // undefined codes leave the deque alone and are refused
            st.accepted = 1'b0;
         end
      endcase
      st.empty = (entry_cnt == 0);
      st.full  = (entry_cnt >= lim);
      if (st.empty) begin
         st.front_word = EMPTY_WORD;
         st.rear_word  = EMPTY_WORD;
      end else begin
         st.front_word = ring_words[head_idx];
         st.rear_word  = ring_words[(head_idx + entry_cnt - 1) % RING_DEPTH];
      end
      return st;
   endfunction

   task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // sample all ports at the clock edge
   always @(posedge clock) begin
      deque_status_type want;
      if (reset) begin
         head_idx     = 0;
         entry_cnt    = 0;
         capacity_reg = CAP_RESET;
         pending_status.delete();
      end else begin
         // register write
         if (psel && penable && pwrite && pready && paddr == CSR_CAPACITY_ADDR)
            capacity_reg = pwdata[CAP_W-1:0];
         // result item against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_status.size() == 0) begin
               report_mismatch("unexpected result, front_value", rsp_mon.front_value, '0);
            end else begin
               want = pending_status.pop_front();
               if (rsp_mon.accepted !== want.accepted)
                  report_mismatch("accepted", DATA_W'(rsp_mon.accepted), DATA_W'(want.accepted));
               if (rsp_mon.front_value !== want.front_word)
                  report_mismatch("front_value", rsp_mon.front_value, want.front_word);
               if (rsp_mon.rear_value !== want.rear_word)
                  report_mismatch("rear_value", rsp_mon.rear_value, want.rear_word);
               if (rsp_mon.is_empty !== want.empty)
                  report_mismatch("is_empty", DATA_W'(rsp_mon.is_empty), DATA_W'(want.empty));
               if (rsp_mon.is_full !== want.full)
                  report_mismatch("is_full", DATA_W'(rsp_mon.is_full), DATA_W'(want.full));
            end
         end
         // request item
         if (req_mon.valid && req_mon.ready)
            pending_status.push_back(apply_deque_action(req_mon.action, req_mon.value));
      end
      pending_count <= pending_status.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bounded double-ended queue unit: a directed
// pass over empty, full, lowered and zero capacity and undefined actions, then
// biased random fill and drain runs over many capacities and idle and stall mixes.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bdq_pkg::*;

   localparam int SEG_ITEMS = 40;
   localparam int SEG_COUNT = 16;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    pending_count;
   int                    idle_pct  = 0;
   int                    stall_pct = 0;

   bdq_req_if req_if ();
   bdq_rsp_if rsp_if ();

   bounded_double_ended_queue_unit #(.DEPTH(16)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   bdq_deque_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // hands one item over; valid stays high unless a gap is taken
   task automatic send_item(action_type act, logic [DATA_W-1:0] word);
      if ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.value  <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // register write, setup then access; upper data bits are don't-care
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_CAPACITY_ADDR;
      pwdata  <= {(CSR_DATA_W - CAP_W)'($urandom()), cap};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // biased action choice so that runs reach full and empty
   function automatic action_type pick_action(logic filling);
      int r;
      r = $urandom_range(99);
      if (r < 3)
         return action_type'(3'd5 + 3'($urandom_range(2)));
      if (r < 10)
         return ACT_REPORT;
      if (r < (filling ? 62 : 35))
         return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
   endfunction

   initial begin
      logic [CAP_W-1:0] seg_caps [SEG_COUNT];
      int               seg_idle [4];
      int               seg_stall [4];
      logic             filling;
      seg_caps  = '{5'd1, 5'd31, 5'd4, 5'd0, 5'd16, 5'd2, 5'd9, 5'd17,
                    5'd5, 5'd12, 5'd3, 5'd16, 5'd8, 5'd1, 5'd31, 5'd6};
      seg_idle  = '{0, 62, 0, 21};
      seg_stall = '{0, 0, 62, 21};
      filling   = 1'b1;

      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.action <= ACT_REPORT;
      req_if.value  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty deque at reset capacity, undefined codes
      send_item(ACT_REPORT, 32'h1234_5678);
      send_item(ACT_POP_FRONT, 32'h0);
      send_item(ACT_POP_BACK, 32'hFFFF_FFFF);
      send_item(action_type'(3'd5), 32'hA5A5_A5A5);
      send_item(action_type'(3'd6), 32'h5A5A_5A5A);
      send_item(action_type'(3'd7), 32'hFFFF_FFFF);
      // extremes at both ends, an all-ones word held as data
      send_item(ACT_PUSH_FRONT, 32'h8000_0000);
      send_item(ACT_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(ACT_PUSH_FRONT, 32'h0000_0000);
      send_item(ACT_PUSH_BACK, 32'hFFFF_FFFF);
      send_item(ACT_PUSH_BACK, 32'h5555_AAAA);
      send_item(ACT_REPORT, 32'h0);
      wait_quiet();

      // capacity lowered below the count: full, pushes refused, pops work
      write_capacity(5'd3);
      send_item(ACT_PUSH_BACK, 32'hDEAD_BEEF);
      send_item(ACT_PUSH_FRONT, 32'hCAFE_F00D);
      send_item(ACT_POP_FRONT, 32'h0);
      send_item(ACT_POP_BACK, 32'h0);
      send_item(ACT_REPORT, 32'h0);
      send_item(action_type'(3'd7), 32'h0);
      send_item(ACT_POP_FRONT, 32'h0);
      send_item(ACT_POP_BACK, 32'h0);
      send_item(ACT_POP_FRONT, 32'h0);
      send_item(ACT_POP_BACK, 32'h0);
      wait_quiet();

      // capacity zero acts as one
      write_capacity(5'd0);
      send_item(ACT_PUSH_FRONT, 32'h0F0F_0F0F);
      send_item(ACT_PUSH_BACK, 32'hF0F0_F0F0);
      send_item(ACT_POP_BACK, 32'h0);

      // random fill and drain runs
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         wait_quiet();
         write_capacity(seg_caps[seg]);
         idle_pct  = seg_idle[seg / 4];
         stall_pct = seg_stall[seg / 4];
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if ($urandom_range(14) == 0) filling = ~filling;
            send_item(pick_action(filling), pick_word());
            if ($urandom_range(49) == 0) wait_quiet();
         end
      end

      idle_pct  = 0;
      stall_pct = 0;
      wait_quiet();
      if (mismatch_count == 0) begin
         $display("bounded_double_ended_queue_unit: match");
      end else begin
         $display("bounded_double_ended_queue_unit: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("bounded_double_ended_queue_unit: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdq_pkg.sv
rtl/bdq_req_if.sv
rtl/bdq_rsp_if.sv
rtl/bdq_ctrl.sv
rtl/bdq_dpath.sv
rtl/bounded_double_ended_queue_unit.sv
tb/bdq_deque_checker.sv
tb/tb_top.sv
